// File: sv/p4pb_pkg.sv
// Package for the packed 4bpp page blitter: page geometry defaults, command codes,
// palette luminance function. No dependencies.
`default_nettype none
package p4pb_pkg;
	localparam int PAGE_PITCH_D   = 160;
	localparam int PAGE_WIDTH_D   = 320;
	localparam int PAGE_HEIGHT_D  = 200;
	localparam int PAGE_BYTES_D   = 32000;
	localparam int TEXT_COLUMNS_D = 40;

	localparam logic [2:0] MODE_WRITE = 3'd0;
	localparam logic [2:0] MODE_READ  = 3'd1;
	localparam logic [2:0] MODE_FILL  = 3'd2;
	localparam logic [2:0] MODE_GLYPH = 3'd3;
	localparam logic [2:0] MODE_REMAP = 3'd4;

	localparam int PAL_W = 48;

	// 2-bit luminance of one 12-bit palette entry (R,G,B nibbles)
	function automatic logic [3:0] luma(input logic [11:0] e);
		logic [17:0] s;
		s = 18'(e[11:8]) * 18'd77 + 18'(e[7:4]) * 18'd151 + 18'(e[3:0]) * 18'd28;
		return {2'b00, s[11:10]};
	endfunction
endpackage
`default_nettype wire

// File: sv/p4pb_page_ram.sv
// Page memory: one write port, one registered read port.
// Depends on nothing but its parameters.
`default_nettype none
module p4pb_page_ram #(
	parameter int DEPTH = 32000,
	parameter int AW    = 15
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic [7:0]         rdata
);
	logic [7:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: sv/packed_4bpp_page_blitter_top.sv
// Top level of the packed 4bpp page blitter: command sequencer around the page memory.
// Depends on p4pb_pkg and p4pb_page_ram.
//
// Usage: a command word enters on s_axis (tvalid/tready/tdata); exactly one result
// word leaves on m_axis. The user is to write palette registers through cfg_we/
// cfg_index/cfg_data while idle; the block does not enforce it. The sequencer
// walks page bytes through a read, merge and write-back loop on the one page
// memory: for fill, glyph and remap the registered read data of each touched byte
// is merged and written back in the cycle after the read. A rejected glyph, empty
// fill or unused mode touches no page byte. The next word is accepted only in the
// cycle after the result has left the output register; a stalled receiver
// therefore holds the block. Reset clears the sequencer, the output register and
// the palette; page contents stay undefined until written.
`default_nettype none
module packed_4bpp_page_blitter_top
	import p4pb_pkg::*;
#(
	parameter int PAGE_PITCH   = PAGE_PITCH_D,
	parameter int PAGE_WIDTH   = PAGE_WIDTH_D,
	parameter int PAGE_HEIGHT  = PAGE_HEIGHT_D,
	parameter int PAGE_BYTES   = PAGE_BYTES_D,
	parameter int TEXT_COLUMNS = TEXT_COLUMNS_D
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// mode[2:0], address[17:3], write_data[25:18], x_pos[35:26], y_pos[44:36],
	// rect_width[53:45], rect_height[61:54], color[65:62], cell_column[71:66],
	// glyph_rows[135:72], zero[143:136]
	input  wire logic [143:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// read_data[7:0], skipped[8], zero[15:9]
	output logic [15:0]       m_axis_tdata,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [47:0]  cfg_data
);
	localparam int AW = $clog2(PAGE_BYTES + 1);
	localparam int RW = $clog2(PAGE_HEIGHT + 1);
	localparam int CW = $clog2(PAGE_WIDTH + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1; // issue read
	localparam logic [2:0] ST_WR   = 3'd2; // merge and write back
	localparam logic [2:0] ST_OUT  = 3'd3;
	localparam logic [2:0] ST_RDW  = 3'd4; // read-byte wait

	logic [2:0]  state_q;
	logic [2:0]  mode_q;
	logic [3:0]  colour_q;
	logic [63:0] rows_q;
	logic [AW-1:0] addr_q;
	logic [7:0]  wdata_q;
	logic [RW-1:0] row_q, row_end_q;
	logic [CW-1:0] col_q, col0_q, col_end_q; // pixel columns, col_end exclusive
	logic [2:0]  gcnt_q;  // glyph byte within row
	logic [RW-1:0] grow_q; // glyph row 0..7 (stored wide)
	logic [AW-1:0] row_base_q;
	logic [PAL_W-1:0] pal_q [4];
	logic [7:0]  rd_res_q;
	logic        sk_res_q;
	logic        out_v_q;

	logic        ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]  ram_wdata, ram_rdata;

	p4pb_page_ram #(.DEPTH(PAGE_BYTES), .AW(AW)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// command fields
	logic [2:0]  in_mode;
	logic [14:0] in_addr;
	logic signed [9:0] in_x;
	logic signed [8:0] in_y;
	logic [8:0]  in_w;
	logic [7:0]  in_h;
	logic [5:0]  in_cell;
	assign in_mode = s_axis_tdata[2:0];
	assign in_addr = s_axis_tdata[17:3];
	assign in_x    = s_axis_tdata[35:26];
	assign in_y    = s_axis_tdata[44:36];
	assign in_w    = s_axis_tdata[53:45];
	assign in_h    = s_axis_tdata[61:54];
	assign in_cell = s_axis_tdata[71:66];

	// fill clipping
	logic signed [12:0] fx0, fx1, fy0, fy1;
	always_comb begin
		fx0 = (in_x < 0) ? 13'sd0 : 13'(in_x);
		fx1 = 13'(in_x) + 13'(in_w);
		if (fx1 > 13'(PAGE_WIDTH)) fx1 = 13'(PAGE_WIDTH);
		fy0 = (in_y < 0) ? 13'sd0 : 13'(in_y);
		fy1 = 13'(in_y) + 13'(in_h);
		if (fy1 > 13'(PAGE_HEIGHT)) fy1 = 13'(PAGE_HEIGHT);
	end
	logic fill_empty, glyph_skip;
	assign fill_empty = (fx0 >= fx1) || (fy0 >= fy1);
	assign glyph_skip = (32'(in_cell) > 32'(TEXT_COLUMNS - 1)) || (in_y < 0) ||
		(32'(in_y) > 32'(PAGE_HEIGHT - 8));

	// current byte address and pixel coverage within it
	logic [AW+1:0] cur_addr_w;
	logic [AW-1:0] cur_addr;
	logic          cur_ok;
	logic          hi_on, lo_on;
	logic [7:0]    gbits;
	always_comb begin
		gbits = rows_q[8'(63 - 8 * 32'(grow_q[2:0])) -: 8];
		hi_on = 1'b0;
		lo_on = 1'b0;
		cur_addr_w = (AW+2)'(row_base_q) + (AW+2)'(col_q >> 1);
		case (mode_q)
			MODE_FILL: begin
				hi_on = !col_q[0];
				lo_on = (col_q[0] || (col_q + 1'b1 < col_end_q));
			end
			MODE_GLYPH: begin
				hi_on = gbits[3'd7 - {gcnt_q[1:0], 1'b0}];
				lo_on = gbits[3'd6 - {gcnt_q[1:0], 1'b0}];
			end
			MODE_REMAP: begin
				cur_addr_w = (AW+2)'(addr_q);
				hi_on = 1'b1;
				lo_on = 1'b1;
			end
			default: begin
				cur_addr_w = (AW+2)'(addr_q);
			end
		endcase
		cur_ok = cur_addr_w < (AW+2)'(PAGE_BYTES);
		cur_addr = cur_addr_w[AW-1:0];
	end

	// palette lookup for remap
	logic [3:0] lhi, llo;
	logic [11:0] ehi, elo;
	always_comb begin
		ehi = pal_q[ram_rdata[7:6]][12*ram_rdata[5:4] +: 12];
		elo = pal_q[ram_rdata[3:2]][12*ram_rdata[1:0] +: 12];
		lhi = luma(ehi);
		llo = luma(elo);
	end

	// merged byte
	logic [7:0] merged;
	always_comb begin
		merged = ram_rdata;
		if (mode_q == MODE_REMAP) begin
			merged = {lhi, llo};
		end else begin
			if (hi_on) merged[7:4] = colour_q;
			if (lo_on) merged[3:0] = colour_q;
		end
	end

	assign ram_raddr = cur_addr;
	assign ram_waddr = cur_addr;
	assign ram_we = ((state_q == ST_WR) && cur_ok && (hi_on || lo_on)) ||
		((state_q == ST_RD) && (mode_q == MODE_WRITE) && cur_ok);
	assign ram_wdata = (mode_q == MODE_WRITE) ? wdata_q : merged;

	assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {7'd0, sk_res_q, rd_res_q};

	// palette registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) pal_q[i] <= '0;
		end else if (cfg_we) begin
			pal_q[cfg_index] <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			out_v_q  <= 1'b0;
			rd_res_q <= '0;
			sk_res_q <= 1'b0;
		end else begin
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						mode_q   <= in_mode;
						addr_q   <= AW'(in_addr);
						wdata_q  <= s_axis_tdata[25:18];
						rd_res_q <= '0;
						sk_res_q <= 1'b0;
						rows_q   <= s_axis_tdata[135:72];
						grow_q   <= '0;
						gcnt_q   <= '0;
						case (in_mode)
							MODE_WRITE: state_q <= ST_RD;
							MODE_READ:  state_q <= ST_RDW;
							MODE_FILL: begin
								colour_q   <= s_axis_tdata[65:62];
								col0_q     <= CW'(fx0);
								col_q      <= CW'(fx0);
								col_end_q  <= CW'(fx1);
								row_q      <= RW'(fy0);
								row_end_q  <= RW'(fy1);
								row_base_q <= AW'(32'(fy0) * PAGE_PITCH);
								state_q    <= fill_empty ? ST_OUT : ST_RD;
							end
							MODE_GLYPH: begin
								colour_q   <= s_axis_tdata[65:62] + 4'd2;
								col_q      <= CW'(32'(in_cell) * 8);
								col0_q     <= CW'(32'(in_cell) * 8);
								row_base_q <= AW'(32'(in_y) * PAGE_PITCH);
								sk_res_q   <= glyph_skip;
								state_q    <= glyph_skip ? ST_OUT : ST_RD;
							end
							MODE_REMAP: begin
								addr_q  <= '0;
								state_q <= ST_RD;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_RDW: begin
					state_q <= ST_OUT;
				end
				ST_RD: begin
					state_q <= (mode_q == MODE_WRITE) ? ST_OUT : ST_WR;
				end
				ST_WR: begin
					state_q <= ST_RD;
					case (mode_q)
						MODE_FILL: begin
							// last byte of the row: back to the left edge of the next row
							if ((col_q | CW'(1)) + 1'b1 >= col_end_q) begin
								col_q <= col0_q;
								row_q <= row_q + 1'b1;
								row_base_q <= row_base_q + AW'(PAGE_PITCH);
								if (row_q + 1'b1 >= row_end_q) state_q <= ST_OUT;
							end else begin
								col_q <= (col_q | CW'(1)) + 1'b1;
							end
						end
						MODE_GLYPH: begin
							if (gcnt_q == 3'd3) begin
								gcnt_q <= '0;
								col_q  <= col0_q;
								grow_q <= grow_q + 1'b1;
								row_base_q <= row_base_q + AW'(PAGE_PITCH);
								if (grow_q == RW'(7)) state_q <= ST_OUT;
							end else begin
								gcnt_q <= gcnt_q + 1'b1;
								col_q  <= col_q + CW'(2);
							end
						end
						default: begin
							addr_q <= addr_q + 1'b1;
							if (32'(addr_q) == PAGE_BYTES - 1) state_q <= ST_OUT;
						end
					endcase
				end
				ST_OUT: begin
					if (mode_q == MODE_READ && 32'(addr_q) < PAGE_BYTES) begin
						rd_res_q <= ram_rdata;
					end
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for packed_4bpp_page_blitter_top: defines the page with a
// full fill, then runs directed and random blit commands against a behavioral page model.
// Depends on p4pb_pkg and the blitter RTL.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import p4pb_pkg::*;

	localparam int PITCH = 160;
	localparam int WIDTH = 320;
	localparam int HEIGHT = 200;
	localparam int BYTES = 32000;
	localparam int COLS = 40;
	localparam logic [2:0] MODE_SPARE = 3'd5;

	typedef struct {
		logic [2:0]        mode;
		logic [14:0]       addr;
		logic [7:0]        wdata;
		logic signed [9:0] x;
		logic signed [8:0] y;
		logic [8:0]        w;
		logic [7:0]        h;
		logic [3:0]        color;
		logic [5:0]        cell_col;
		logic [63:0]       rows;
	} blit_cmd_t;

	typedef struct {
		logic [7:0] rdata;
		logic       skipped;
	} blit_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// mode, address, write_data, x_pos, y_pos, rect_width, rect_height, color,
	// cell_column, glyph_rows, zero pad (lowest bit up)
	logic [143:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// read_data, skipped, zero pad (lowest bit up)
	logic [15:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [47:0] cfg_data = '0;

	packed_4bpp_page_blitter_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// page model and palette copy
	logic [7:0]  page_mem [0:BYTES-1];
	logic [47:0] palette [0:3];

	blit_cmd_t cmd_queue[$];
	blit_res_t result_queue[$];
	int issued = 0;
	int accepted = 0;
	int errors = 0;
	int mode_count [0:7];
	int skip_count = 0;
	int hold_req = 0;
	int hold_done = 0;
	logic word_taken = 1'b0;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void put_px(input int row, input int col, input logic [3:0] c);
		int a;
		a = row * PITCH + (col >> 1);
		if (a >= BYTES) return;
		if (col & 1) page_mem[a][3:0] = c;
		else page_mem[a][7:4] = c;
	endfunction

	function automatic logic [3:0] gray_of(input int k);
		logic [11:0] e;
		int s;
		e = 12'(palette[k >> 2] >> (12 * (k & 3)));
		s = int'(e[11:8]) * 77 + int'(e[7:4]) * 151 + int'(e[3:0]) * 28;
		return 4'((s >> 10) & 15);
	endfunction

	// apply one command to the page model, return the expected result word
	function automatic blit_res_t blit_predict(input blit_cmd_t c);
		blit_res_t r;
		int x0, y0, x1, y1;
		logic [3:0] ink;
		logic [3:0] map [0:15];
		r.rdata = '0;
		r.skipped = 1'b0;
		case (c.mode)
			MODE_WRITE: if (c.addr < BYTES) page_mem[c.addr] = c.wdata;
			MODE_READ: if (c.addr < BYTES) r.rdata = page_mem[c.addr];
			MODE_FILL: begin
				x0 = c.x; y0 = c.y;
				x1 = x0 + int'(c.w); y1 = y0 + int'(c.h);
				if (x0 < 0) x0 = 0;
				if (y0 < 0) y0 = 0;
				if (x1 > WIDTH) x1 = WIDTH;
				if (y1 > HEIGHT) y1 = HEIGHT;
				for (int py = y0; py < y1; py++)
					for (int px = x0; px < x1; px++)
						put_px(py, px, c.color);
			end
			MODE_GLYPH: begin
				ink = c.color + 4'd2;
				if (c.cell_col > COLS - 1 || c.y < 0 || int'(c.y) > HEIGHT - 8) begin
					r.skipped = 1'b1;
				end else begin
					for (int j = 0; j < 8; j++)
						for (int i = 0; i < 8; i++)
							if (c.rows[63 - 8 * j - i])
								put_px(int'(c.y) + j, int'(c.cell_col) * 8 + i, ink);
				end
			end
			MODE_REMAP: begin
				for (int k = 0; k < 16; k++) map[k] = gray_of(k);
				for (int a = 0; a < BYTES; a++)
					page_mem[a] = {map[page_mem[a][7:4]], map[page_mem[a][3:0]]};
			end
			default: ;
		endcase
		return r;
	endfunction

	// sender: bursts of random length, random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		blit_cmd_t c;
		logic next_valid;
		next_valid = s_axis_tvalid;
		if (!s_axis_tvalid || word_taken) begin
			next_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (cmd_queue.size() > 0) begin
				c = cmd_queue.pop_front();
				s_axis_tdata <= {8'b0, c.rows, c.cell_col, c.color, c.h, c.w, c.y, c.x,
					c.wdata, c.addr, c.mode};
				next_valid = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		s_axis_tvalid <= next_valid;
	end

	// receiver: stall pattern switched at random among three styles, plus long hold-offs on request
	int rx_phase = 0;
	int rx_style = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (hold_req != hold_done) begin
			hold_done = hold_req;
			hold_left = 400;
		end
		if (rx_phase == 0) begin
			rx_phase = 64;
			rx_style = $urandom_range(0, 2);
		end
		rx_phase--;
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_style)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// accepted commands feed the model; returned words are checked
	always @(posedge clk) begin
		blit_cmd_t c;
		blit_res_t want;
		word_taken <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			{c.rows, c.cell_col, c.color, c.h, c.w, c.y, c.x, c.wdata, c.addr, c.mode} =
				s_axis_tdata[135:0];
			result_queue.push_back(blit_predict(c));
			mode_count[c.mode]++;
			accepted++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (result_queue.size() == 0) begin
				report("unexpected word", int'(m_axis_tdata), 0);
			end else begin
				want = result_queue.pop_front();
				if (m_axis_tdata[7:0] !== want.rdata)
					report("read_data", int'(m_axis_tdata[7:0]), int'(want.rdata));
				if (m_axis_tdata[8] !== want.skipped)
					report("skipped", int'(m_axis_tdata[8]), int'(want.skipped));
				if (want.skipped) skip_count++;
			end
		end
	end

	task automatic send(input blit_cmd_t c);
		cmd_queue.push_back(c);
		issued++;
	endtask

	task automatic wait_idle();
		wait (accepted == issued && result_queue.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_palette(input logic [1:0] idx, input logic [47:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		palette[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all_palettes(input int style);
		for (int i = 0; i < 4; i++)
			case (style)
				0: set_palette(2'(i), '0);
				1: set_palette(2'(i), '1);
				default: set_palette(2'(i), 48'({$urandom, $urandom}));
			endcase
	endtask

	function automatic blit_cmd_t blank(input logic [2:0] m);
		blit_cmd_t c;
		c = '{default: '0};
		c.mode = m;
		return c;
	endfunction

	function automatic blit_cmd_t random_cmd();
		blit_cmd_t c;
		int pick;
		c = '{default: '0};
		c.addr = 15'($urandom_range(0, 32767));
		c.wdata = 8'($urandom);
		c.x = 10'($urandom);
		c.y = 9'($urandom);
		c.color = 4'($urandom);
		c.cell_col = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
			6'($urandom_range(0, 39));
		c.rows = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		// mostly small rectangles near the page; a few at full size
		if ($urandom_range(0, 19) == 0) begin
			c.w = 9'($urandom);
			c.h = 8'($urandom);
		end else begin
			c.w = 9'($urandom_range(0, 24));
			c.h = 8'($urandom_range(0, 16));
			c.x = 10'(int'($urandom_range(0, 360)) - 20);
		end
		if (pick < 25) c.mode = MODE_WRITE;
		else if (pick < 50) c.mode = MODE_READ;
		else if (pick < 70) c.mode = MODE_FILL;
		else if (pick < 94) c.mode = MODE_GLYPH;
		else if (pick < 96) c.mode = MODE_REMAP;
		else c.mode = 3'($urandom_range(int'(MODE_SPARE), 7));
		if (c.mode == MODE_GLYPH && pick < 88) c.y = 9'($urandom_range(0, 192));
		return c;
	endfunction

	initial begin
		blit_cmd_t c;
		for (int i = 0; i < 8; i++) mode_count[i] = 0;
		for (int i = 0; i < 4; i++) palette[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_all_palettes(0);

		// a full-page fill defines every byte before anything reads it back
		c = blank(MODE_FILL); c.w = 9'd320; c.h = 8'd200; c.color = 4'($urandom); send(c);
		for (int n = 0; n < 8; n++) begin
			c = blank(MODE_WRITE);
			c.addr = 15'($urandom_range(0, BYTES - 1));
			c.wdata = 8'($urandom);
			send(c);
		end
		wait_idle();

		// directed corners
		c = blank(MODE_READ); c.addr = '0; send(c);
		c.addr = 15'(BYTES - 1); send(c);
		c.addr = 15'(BYTES); send(c);
		c.addr = 15'h7FFF; send(c);
		c = blank(MODE_WRITE); c.addr = 15'h7FFF; c.wdata = 8'hFF; send(c);
		c.addr = '0; send(c);
		c.addr = 15'(BYTES - 1); c.wdata = 8'h00; send(c);
		c = blank(MODE_FILL); c.w = 9'd320; c.h = 8'd200; c.color = 4'd5; send(c);
		c.x = 10'sh200; c.y = 9'sd3; c.w = 9'd511; c.h = 8'd4; c.color = 4'hF; send(c);
		c.x = 10'sd7; c.y = 9'sh100; c.w = 9'd9; c.h = 8'd255; c.color = 4'h0; send(c);
		c.x = 10'sd319; c.y = 9'sd190; c.w = 9'd511; c.h = 8'd255; c.color = 4'hA; send(c);
		c.x = 10'sd511; c.y = 9'sd255; c.w = 9'd5; c.h = 8'd5; send(c);
		c.x = 10'sd4; c.y = 9'sd4; c.w = 9'd0; c.h = 8'd9; send(c);
		c = blank(MODE_GLYPH); c.cell_col = 6'd39; c.y = 9'sd192; c.rows = '1;
		c.color = 4'd14;
		send(c);
		c.cell_col = 6'd0; c.y = 9'sd0; c.rows = {$urandom, $urandom}; c.color = 4'd15;
		send(c);
		c.cell_col = 6'd40; send(c);
		c.cell_col = 6'd63; send(c);
		c.cell_col = 6'd5; c.y = -9'sd1; send(c);
		c.y = 9'sd193; send(c);
		c.y = 9'sd255; send(c);
		for (int m = int'(MODE_SPARE); m < 8; m++) begin
			c = blank(3'(m)); c.addr = 15'd1; c.rows = '1; send(c);
		end
		send(blank(MODE_REMAP));
		c = blank(MODE_READ); c.addr = 15'd321; send(c);
		wait_idle();

		set_all_palettes(1);
		send(blank(MODE_REMAP));
		c = blank(MODE_READ); c.addr = 15'd100; send(c);
		wait_idle();

		// random traffic, with palette changes between halves
		for (int phase = 0; phase < 2; phase++) begin
			set_all_palettes(2);
			for (int n = 0; n < 30; n++) begin
				send(random_cmd());
				if (n == 10) hold_req++;
			end
			wait_idle();
		end

		repeat (50) @(posedge clk);
		$display("covered %0d commands: write %0d read %0d fill %0d glyph %0d remap %0d spare %0d",
			accepted, mode_count[0], mode_count[1], mode_count[2], mode_count[3],
			mode_count[4], mode_count[5] + mode_count[6] + mode_count[7]);
		$display("glyphs rejected %0d, palette settings zero, full and random", skip_count);
		if (errors == 0)
			$display("[packed_4bpp_page_blitter_top] OK");
		else
			$display("[packed_4bpp_page_blitter_top] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#200_000_000;
		$display("timeout with %0d words outstanding", result_queue.size());
		$display("[packed_4bpp_page_blitter_top] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
